/* sv/jia_pkg.sv */
// ----------------------------------------------------------------------------
// jia_pkg: shared types and constants of the integer ALU
// Operation codes, the decoded item record passed from front to back end.
// ----------------------------------------------------------------------------
package jia_pkg;

    localparam int unsigned DataW   = 64;
    localparam int unsigned CmdW    = 5;
    localparam int unsigned QDepth  = 2;
    localparam int unsigned QIdxW   = 1;
    localparam int unsigned DivStg  = 64;
    localparam int unsigned MulStg  = 4;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_REM  = 4'd4,
        OP_NEG  = 4'd5,
        OP_SHL  = 4'd6,
        OP_SHR  = 4'd7,
        OP_USHR = 4'd8,
        OP_AND  = 4'd9,
        OP_OR   = 4'd10,
        OP_XOR  = 4'd11,
        OP_NONE = 4'd12
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        is_long;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
    } t_item;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        sext32 = {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

/* sv/jia_front.sv */
// ----------------------------------------------------------------------------
// jia_front: input decode
// Classifies the command, narrows operands for int forms, masks the count.
// ----------------------------------------------------------------------------
module jia_front import jia_pkg::*; (
    input  logic [4:0]  i_command,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output t_item       o_item
);
    logic is_long;
    logic [3:0] opc;

    always_comb begin
        is_long = i_command[0];
        opc     = i_command[4:1];
        o_item.is_long = is_long;
        o_item.a  = is_long ? i_operand_a : sext32(i_operand_a);
        o_item.b  = is_long ? i_operand_b : sext32(i_operand_b);
        o_item.sh = is_long ? i_operand_b[5:0] : {1'b0, i_operand_b[4:0]};
        case (opc)
            4'd0:    o_item.op = OP_ADD;
            4'd1:    o_item.op = OP_SUB;
            4'd2:    o_item.op = OP_MUL;
            4'd3:    o_item.op = OP_DIV;
            4'd4:    o_item.op = OP_REM;
            4'd5:    o_item.op = OP_NEG;
            4'd6:    o_item.op = OP_SHL;
            4'd7:    o_item.op = OP_SHR;
            4'd8:    o_item.op = OP_USHR;
            4'd9:    o_item.op = OP_AND;
            4'd10:   o_item.op = OP_OR;
            4'd11:   o_item.op = OP_XOR;
            default: o_item.op = OP_NONE;
        endcase
    end
endmodule

/* sv/jia_queue.sv */
// ----------------------------------------------------------------------------
// jia_queue: two-entry decoded item queue
// Decouples front-end acceptance from back-end stalls.
// ----------------------------------------------------------------------------
module jia_queue import jia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item r_mem [QDepth];
    logic [QIdxW-1:0] r_wp, r_rp;
    logic [QIdxW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QIdxW+1)'(push) - (QIdxW+1)'(pop);
        end
    end
endmodule

/* sv/jia_back.sv */
// ----------------------------------------------------------------------------
// jia_back: execution pipeline
// Fixed-length pipeline: one radix-2 divide step per stage, a 4-stage split
// multiplier, other ops carried along; all items leave in order.
// ----------------------------------------------------------------------------
module jia_back import jia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result,
    output logic        o_divide_by_zero
);
    localparam int unsigned NStg = DivStg + 2;

    // per-stage state
    logic        r_v   [NStg];
    t_op         r_op  [NStg];
    logic        r_lg  [NStg];
    logic [63:0] r_res [NStg];   // simple result, or partial product sum
    logic [63:0] r_rem [NStg];
    logic [63:0] r_quo [NStg];   // dividend shifting into quotient
    logic [63:0] r_dvs [NStg];
    logic [63:0] r_ma  [NStg];   // mul operand a
    logic [63:0] r_mb  [NStg];
    logic        r_qn  [NStg];
    logic        r_rn  [NStg];
    logic        r_dz  [NStg];

    logic        r_ov;
    logic [63:0] r_ores;
    logic        r_odz;
    logic        adv;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ov;
    assign o_result = r_ores;
    assign o_divide_by_zero = r_odz;

    // stage 0: simple ops and divide/mul setup
    logic [63:0] s_res, a, b, ma, mb;
    logic na, nb, dz;
    always_comb begin
        a = i_item.a;
        b = i_item.b;
        na = a[63];
        nb = b[63];
        ma = na ? (64'd0 - a) : a;
        mb = nb ? (64'd0 - b) : b;
        dz = (b == 64'd0);
        case (i_item.op)
            OP_ADD:  s_res = a + b;
            OP_SUB:  s_res = a - b;
            OP_NEG:  s_res = 64'd0 - a;
            OP_SHL:  s_res = a << i_item.sh;
            OP_SHR:  s_res = $signed(a) >>> i_item.sh;
            OP_USHR: s_res = i_item.is_long ? (a >> i_item.sh)
                                            : ({32'd0, a[31:0]} >> i_item.sh);
            OP_AND:  s_res = a & b;
            OP_OR:   s_res = a | b;
            OP_XOR:  s_res = a ^ b;
            default: s_res = 64'd0;
        endcase
    end

    // step logic for stage k (k>=1 does a divide step; 1..MulStg add products)
    logic [64:0] trial [NStg];
    logic [63:0] remsh [NStg];
    logic [63:0] pp    [NStg];
    always_comb begin
        for (int k = 0; k < NStg; k++) begin
            remsh[k] = {r_rem[k][62:0], r_quo[k][63]};
            trial[k] = {1'b0, remsh[k]} - {1'b0, r_dvs[k]};
            pp[k] = '0;
        end
        for (int k = 0; k < MulStg; k++) begin
            pp[k] = 64'(r_ma[k][k*16 +: 16] * r_mb[k]) << (k*16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NStg; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NStg; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[NStg-1];
        end
        if (adv) begin
            r_op[0] <= i_item.op;
            r_lg[0] <= i_item.is_long;
            r_res[0] <= s_res;
            r_rem[0] <= '0;
            r_quo[0] <= ma;
            r_dvs[0] <= mb;
            r_ma[0] <= a;
            r_mb[0] <= b;
            r_qn[0] <= na ^ nb;
            r_rn[0] <= na;
            r_dz[0] <= dz;
            for (int k = 1; k < NStg; k++) begin
                r_op[k] <= r_op[k-1];
                r_lg[k] <= r_lg[k-1];
                r_ma[k] <= r_ma[k-1];
                r_mb[k] <= r_mb[k-1];
                r_qn[k] <= r_qn[k-1];
                r_rn[k] <= r_rn[k-1];
                r_dz[k] <= r_dz[k-1];
                r_dvs[k] <= r_dvs[k-1];
                if (k <= DivStg) begin
                    if (!trial[k-1][64]) begin
                        r_rem[k] <= trial[k-1][63:0];
                        r_quo[k] <= {r_quo[k-1][62:0], 1'b1};
                    end else begin
                        r_rem[k] <= remsh[k-1];
                        r_quo[k] <= {r_quo[k-1][62:0], 1'b0};
                    end
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_quo[k] <= r_quo[k-1];
                end
                if (k <= MulStg && r_op[k-1] == OP_MUL) begin
                    r_res[k] <= ((k == 1) ? 64'd0 : r_res[k-1]) + pp[k-1];
                end else begin
                    r_res[k] <= r_res[k-1];
                end
            end
            // final sign fixup and int narrowing
            begin
                logic [63:0] fr;
                logic        fd;
                fd = 1'b0;
                case (r_op[NStg-1])
                    OP_DIV, OP_REM: begin
                        if (r_dz[NStg-1]) begin
                            fr = '0;
                            fd = 1'b1;
                        end else if (r_op[NStg-1] == OP_DIV) begin
                            fr = r_qn[NStg-1] ? (64'd0 - r_quo[NStg-1]) : r_quo[NStg-1];
                        end else begin
                            fr = r_rn[NStg-1] ? (64'd0 - r_rem[NStg-1]) : r_rem[NStg-1];
                        end
                    end
                    default: fr = r_res[NStg-1];
                endcase
                r_ores <= r_lg[NStg-1] ? fr : sext32(fr);
                r_odz  <= fd;
            end
        end
    end
endmodule

/* sv/jvm_integer_alu.sv */
// All ops take the same path; the 64-step divide pipeline sets the latency.
// Throughput: one item per cycle, as long as the output does not stall.
// A 2-entry queue after decode holds up to two items while the output stalls.
// Reset: synchronous active-low i_rst_n clears all valid state; no data cleared.
// ----------------------------------------------------------------------------
// jvm_integer_alu: Java bytecode integer ALU
// Decode front end, item queue, fully pipelined execution back end.
// ----------------------------------------------------------------------------
module jvm_integer_alu import jia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_command,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result,
    output logic        o_divide_by_zero
);
    t_item dec, qitem;
    logic  qv, qr;

    jia_front u_front (
        .i_command(i_command), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .o_item(dec)
    );

    jia_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(dec),
        .o_valid(qv), .i_ready(qr), .o_item(qitem)
    );

    jia_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(qv), .o_ready(qr), .i_item(qitem),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result(o_result), .o_divide_by_zero(o_divide_by_zero)
    );
endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Java bytecode integer ALU
// A directed table covers every operation, operand extremes, zero divisors,
// minimum over minus one and an unused code; random items follow, with random
// idle bursts on both handshakes. Every result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import jia_pkg::*;

    localparam int unsigned LATENCY = 67;
    localparam int unsigned N_RANDOM = 1500;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MIN32 = 64'hffff_ffff_8000_0000;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [4:0] C_IADD = 5'd0, C_LADD = 5'd1, C_ISUB = 5'd2, C_LSUB = 5'd3;
    localparam logic [4:0] C_IMUL = 5'd4, C_LMUL = 5'd5, C_IDIV = 5'd6, C_LDIV = 5'd7;
    localparam logic [4:0] C_IREM = 5'd8, C_LREM = 5'd9, C_INEG = 5'd10, C_LNEG = 5'd11;
    localparam logic [4:0] C_ISHL = 5'd12, C_LSHL = 5'd13, C_ISHR = 5'd14, C_LSHR = 5'd15;
    localparam logic [4:0] C_IUSHR = 5'd16, C_LUSHR = 5'd17, C_IAND = 5'd18, C_LAND = 5'd19;
    localparam logic [4:0] C_IOR = 5'd20, C_LOR = 5'd21, C_IXOR = 5'd22, C_LXOR = 5'd23;
    localparam logic [4:0] C_UNUSED = 5'd31;

    typedef struct {
        logic [63:0] result;
        logic        dz;
    } t_alu_out;

    typedef struct {
        logic [4:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
        logic        known;   // expected result typed in
        logic [63:0] result;
        logic        dz;
    } t_vec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [4:0]  i_command;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result;
    logic        o_divide_by_zero;

    t_alu_out    pending_results[$];
    int unsigned n_errors;
    longint unsigned n_cycles;
    logic        quiet_tail;
    t_vec        vectors[$];

    jvm_integer_alu dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic t_alu_out compute_alu(input logic [4:0] cmd, input logic [63:0] a_in,
                                             input logic [63:0] b_in);
        t_alu_out o;
        logic is_long;
        logic [3:0] op;
        logic [63:0] a, b, ma, mb, mq, mr;
        int unsigned sh;
        is_long = cmd[0];
        op = cmd[4:1];
        a = is_long ? a_in : sx32(a_in);
        b = is_long ? b_in : sx32(b_in);
        sh = is_long ? 32'(b_in[5:0]) : 32'(b_in[4:0]);
        o.result = '0;
        o.dz = 1'b0;
        case (op)
            OP_ADD: o.result = a + b;
            OP_SUB: o.result = a - b;
            OP_MUL: o.result = a * b;
            OP_DIV, OP_REM: begin
                if (b == 0) begin
                    o.dz = 1'b1;
                end else begin
                    ma = a[63] ? -a : a;
                    mb = b[63] ? -b : b;
                    mq = ma / mb;
                    mr = ma % mb;
                    if (op == OP_DIV) o.result = (a[63] != b[63]) ? -mq : mq;
                    else o.result = a[63] ? -mr : mr;
                end
            end
            OP_NEG: o.result = -a;
            OP_SHL: o.result = a << sh;
            OP_SHR: o.result = $signed(a) >>> sh;
            OP_USHR: o.result = is_long ? a >> sh : {32'd0, a[31:0]} >> sh;
            OP_AND: o.result = a & b;
            OP_OR: o.result = a | b;
            OP_XOR: o.result = a ^ b;
            default: o.result = '0;
        endcase
        if (!is_long) o.result = sx32(o.result);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    task automatic add_vec(input logic [4:0] cmd, input logic [63:0] a, input logic [63:0] b,
                           input logic known = 1'b0, input logic [63:0] res = '0,
                           input logic dz = 1'b0);
        t_vec v;
        v.cmd = cmd; v.a = a; v.b = b; v.known = known; v.result = res; v.dz = dz;
        vectors.push_back(v);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = MIN64;
            1: v = MAX64;
            2: v = ONES;
            3: v = '0;
            4: v = sx32(v);
            5: v = 64'($urandom_range(0, 70));
            default: ;
        endcase
        return v;
    endfunction

    // send one item, sometimes idling a random burst first
    task automatic send_item(input logic [4:0] cmd, input logic [63:0] a, input logic [63:0] b,
                             input logic known, input logic [63:0] res, input logic dz);
        t_alu_out e;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        e = compute_alu(cmd, a, b);
        if (known) begin
            if (e.result !== res || e.dz !== dz)
                report_mismatch("table entry", e.result, res);
            e.result = res;
            e.dz = dz;
        end
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(e);
    endtask

    // output side: random stall bursts, then checks
    initial begin
        int unsigned stall;
        t_alu_out e;
        i_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_result, '0);
                end else begin
                    e = pending_results.pop_front();
                    if (o_result !== e.result) report_mismatch("result", o_result, e.result);
                    if (o_divide_by_zero !== e.dz)
                        report_mismatch("divide_by_zero", 64'(o_divide_by_zero), 64'(e.dz));
                end
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 16) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        n_cycles = 0;
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [4:0] cmd;
        n_errors = 0;
        quiet_tail = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_vec(C_IADD, 64'h7fff_ffff, 64'd1, 1'b1, MIN32);
        add_vec(C_LADD, MAX64, 64'd1, 1'b1, MIN64);
        add_vec(C_ISUB, MIN32, 64'd1, 1'b1, 64'h7fff_ffff);
        add_vec(C_LSUB, MIN64, 64'd1, 1'b1, MAX64);
        add_vec(C_IMUL, 64'h1234_5678_9abc_def0, ONES);
        add_vec(C_LMUL, MAX64, MAX64, 1'b1, 64'd1);
        add_vec(C_IDIV, MIN32, ONES, 1'b1, MIN32);
        add_vec(C_LDIV, MIN64, ONES, 1'b1, MIN64);
        add_vec(C_IREM, MIN32, ONES, 1'b1, '0);
        add_vec(C_LREM, MIN64, ONES, 1'b1, '0);
        add_vec(C_IDIV, 64'd7, 64'hffff_ffff_0000_0000, 1'b1, '0, 1'b1);
        add_vec(C_LDIV, 64'd7, '0, 1'b1, '0, 1'b1);
        add_vec(C_IREM, 64'd7, '0, 1'b1, '0, 1'b1);
        add_vec(C_LREM, MIN64, '0, 1'b1, '0, 1'b1);
        add_vec(C_LDIV, -64'sd7, 64'd2, 1'b1, -64'sd3);
        add_vec(C_LREM, -64'sd7, 64'd2, 1'b1, ONES);
        add_vec(C_INEG, MIN32, MAX64, 1'b1, MIN32);
        add_vec(C_LNEG, MIN64, ONES, 1'b1, MIN64);
        add_vec(C_ISHL, 64'd1, 64'd63, 1'b1, MIN32);
        add_vec(C_LSHL, 64'd1, 64'd127, 1'b1, MIN64);
        add_vec(C_ISHR, MIN32, 64'd31, 1'b1, ONES);
        add_vec(C_LSHR, MIN64, 64'd63, 1'b1, ONES);
        add_vec(C_IUSHR, ONES, 64'd28, 1'b1, 64'hf);
        add_vec(C_LUSHR, ONES, 64'd60, 1'b1, 64'hf);
        add_vec(C_IAND, ONES, 64'h5555_5555_aaaa_aaaa);
        add_vec(C_LOR, MIN64, 64'd1);
        add_vec(C_IOR, 64'h1, MIN32);
        add_vec(C_LAND, ONES, MAX64);
        add_vec(C_IXOR, ONES, 64'h0f0f_0f0f_0f0f_0f0f);
        add_vec(C_LXOR, ONES, 64'h0f0f_0f0f_0f0f_0f0f);
        add_vec(C_UNUSED, ONES, ONES, 1'b1, '0);
        foreach (vectors[i])
            send_item(vectors[i].cmd, vectors[i].a, vectors[i].b, vectors[i].known,
                      vectors[i].result, vectors[i].dz);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold off until the pipe drains
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (n == N_RANDOM - 200) quiet_tail = 1'b1;
            cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                               : 5'($urandom_range(0, 23));
            send_item(cmd, rand64(), rand64(), 1'b0, '0, 1'b0);
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* jvm_integer_alu.f */
sv/jia_pkg.sv
sv/jia_front.sv
sv/jia_queue.sv
sv/jia_back.sv
sv/jvm_integer_alu.sv
test/tb_top.sv
